// ----- sv/rmj_pkg.sv -----
package rmj_pkg;

   // Width and reset value of the squared-range threshold register
   localparam int unsigned CSR_W = 32;
   localparam logic [CSR_W-1:0] CSR_RESET = 32'd4295;

endpackage

// ----- sv/radar_measurement_jacobian_core.sv -----
// Radar measurement Jacobian for an extended Kalman filter.
// req channel: one beat per state vector (pos_x, pos_y, vel_x, vel_y), signed
// fixed point with FRAC_BITS fraction bits. rsp channel: one beat per vector with
// the six distinct Jacobian entries, saturated to the same format, and the
// near_zero flag in tuser; when px^2+py^2 is zero or below min_range_squared the
// flag is set and all entries read zero.
// csr channel: writes min_range_squared; always ready. Write it only while idle.
// The square root takes one root bit per stage and each divider one quotient
// bit per stage. Throughput is one beat per cycle while no result beat waits.
// The pipeline advances as a whole: when a result beat waits on rsp_tready,
// every stage holds and req_tready drops, so nothing is lost or repeated.
// Bubbles travel as cleared valid bits.
// Reset clears all valid bits and loads the threshold with 4295 (about 1e-6).
module radar_measurement_jacobian_core #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // pos_x, pos_y, vel_x, vel_y from the lowest bit up
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy from bit 0 up
   output logic [((6*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // near_zero
   output logic rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [rmj_pkg::CSR_W-1:0] csr_data,
   input  logic csr_valid,
   output logic csr_ready
);

   localparam int unsigned W = DATA_WIDTH;
   localparam int unsigned F = FRAC_BITS;
   localparam int unsigned OUT_TW = ((6*DATA_WIDTH+7)/8)*8;
   localparam int unsigned DEPTH = 2*W + 7;

   function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [W-1:0] sat_f(input logic [W-1:0] q, input logic ovf,
                                          input logic neg);
      logic [W-1:0] min_v;
      logic [W-1:0] max_v;
      min_v = {1'b1, {(W-1){1'b0}}};
      max_v = ~min_v;
      if (neg) begin
         if (ovf || q > min_v) return min_v;
         return ~q + 1'b1;
      end
      if (ovf || q[W-1]) return max_v;
      return q;
   endfunction

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   logic [rmj_pkg::CSR_W-1:0] thr_ff;

   // Stall the whole pipeline only while a result beat waits
   assign advance    = ~vld_ff[DEPTH-1] | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= rmj_pkg::CSR_RESET;
      end else begin
         if (advance) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
         if (csr_valid) thr_ff <= csr_data;
      end
   end

   // Stage 1: magnitudes and signs
   logic [W-1:0] mp1_ff, mq1_ff, mvx1_ff, mvy1_ff;
   logic sp1_ff, sq1_ff, svx1_ff, svy1_ff;
   // Stage 2: products
   logic [2*W-1:0] pp2_ff, qq2_ff, a2_ff, b2_ff;
   logic [W-1:0] mp2_ff, mq2_ff;
   logic sp2_ff, sq2_ff, sa2_ff, sb2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         mp1_ff  <= mag_f(req_tdata[W-1:0]);
         mq1_ff  <= mag_f(req_tdata[2*W-1:W]);
         mvx1_ff <= mag_f(req_tdata[3*W-1:2*W]);
         mvy1_ff <= mag_f(req_tdata[4*W-1:3*W]);
         sp1_ff  <= req_tdata[W-1];
         sq1_ff  <= req_tdata[2*W-1];
         svx1_ff <= req_tdata[3*W-1];
         svy1_ff <= req_tdata[4*W-1];

         pp2_ff <= mp1_ff * mp1_ff;
         qq2_ff <= mq1_ff * mq1_ff;
         a2_ff  <= mvx1_ff * mq1_ff;
         b2_ff  <= mvy1_ff * mp1_ff;
         mp2_ff <= mp1_ff;
         mq2_ff <= mq1_ff;
         sp2_ff <= sp1_ff;
         sq2_ff <= sq1_ff;
         sa2_ff <= svx1_ff ^ sq1_ff;
         sb2_ff <= svy1_ff ^ sp1_ff;
      end
   end

   // Stage 3: squared range, near-zero test, cross term C in sign and magnitude
   logic [2*W-1:0] s3_in;
   logic [2*W-1:0] c3_in;
   logic sc3_in;
   logic near3_in;

   always_comb begin
      s3_in    = pp2_ff + qq2_ff;
      near3_in = (s3_in == '0) || (s3_in < (2*W)'(thr_ff));
      if (sa2_ff != sb2_ff) begin
         c3_in  = a2_ff + b2_ff;
         sc3_in = sa2_ff;
      end else if (a2_ff >= b2_ff) begin
         c3_in  = a2_ff - b2_ff;
         sc3_in = sa2_ff;
      end else begin
         c3_in  = b2_ff - a2_ff;
         sc3_in = ~sa2_ff;
      end
   end

   // Square root: index 0 is stage 3, then one root bit per stage
   logic [W+1:0]   rt_rem_ff [0:W];
   logic [W-1:0]   rt_root_ff [0:W];
   logic [2*W-1:0] rt_s_ff [0:W];
   logic [2*W-1:0] rt_c_ff [0:W];
   logic [W-1:0]   rt_mp_ff [0:W];
   logic [W-1:0]   rt_mq_ff [0:W];
   logic           rt_sp_ff [0:W];
   logic           rt_sq_ff [0:W];
   logic           rt_sc_ff [0:W];
   logic           rt_near_ff [0:W];

   always_ff @(posedge clock) begin
      if (advance) begin
         rt_rem_ff[0]  <= '0;
         rt_root_ff[0] <= '0;
         rt_s_ff[0]    <= s3_in;
         rt_c_ff[0]    <= c3_in;
         rt_mp_ff[0]   <= mp2_ff;
         rt_mq_ff[0]   <= mq2_ff;
         rt_sp_ff[0]   <= sp2_ff;
         rt_sq_ff[0]   <= sq2_ff;
         rt_sc_ff[0]   <= sc3_in;
         rt_near_ff[0] <= near3_in;
      end
   end

   genvar k;
   generate
      for (k = 1; k <= W; k++) begin : g_root
         logic [W+3:0] cur_in;
         logic [W+1:0] trial_in;
         logic         ge_in;
         logic [W+3:0] diff_in;

         assign cur_in   = {rt_rem_ff[k-1], rt_s_ff[k-1][2*W-2*k +: 2]};
         assign trial_in = {rt_root_ff[k-1], 2'b01};
         assign ge_in    = (cur_in >= (W+4)'(trial_in));
         assign diff_in  = cur_in - (W+4)'(trial_in);

         always_ff @(posedge clock) begin
            if (advance) begin
               rt_rem_ff[k]  <= ge_in ? diff_in[W+1:0] : cur_in[W+1:0];
               rt_root_ff[k] <= {rt_root_ff[k-1][W-2:0], ge_in};
               rt_s_ff[k]    <= rt_s_ff[k-1];
               rt_c_ff[k]    <= rt_c_ff[k-1];
               rt_mp_ff[k]   <= rt_mp_ff[k-1];
               rt_mq_ff[k]   <= rt_mq_ff[k-1];
               rt_sp_ff[k]   <= rt_sp_ff[k-1];
               rt_sq_ff[k]   <= rt_sq_ff[k-1];
               rt_sc_ff[k]   <= rt_sc_ff[k-1];
               rt_near_ff[k] <= rt_near_ff[k-1];
            end
         end
      end
   endgenerate

   // Partial products of S*R, py*C and px*C, then their sums
   logic [2*W-1:0] dlo_ff, dhi_ff, nqlo_ff, nqhi_ff, nplo_ff, nphi_ff;
   logic [2*W-1:0] s_m1_ff, s_m2_ff;
   logic [W-1:0]   r_m1_ff, r_m2_ff, mp_m1_ff, mp_m2_ff, mq_m1_ff, mq_m2_ff;
   logic           sp_m1_ff, sq_m1_ff, sc_m1_ff, near_m1_ff;
   logic           sp_m2_ff, sq_m2_ff, sc_m2_ff, near_m2_ff;
   logic [3*W-1:0] d_m2_ff, nq_m2_ff, np_m2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dlo_ff     <= rt_s_ff[W][W-1:0] * rt_root_ff[W];
         dhi_ff     <= rt_s_ff[W][2*W-1:W] * rt_root_ff[W];
         nqlo_ff    <= rt_c_ff[W][W-1:0] * rt_mq_ff[W];
         nqhi_ff    <= rt_c_ff[W][2*W-1:W] * rt_mq_ff[W];
         nplo_ff    <= rt_c_ff[W][W-1:0] * rt_mp_ff[W];
         nphi_ff    <= rt_c_ff[W][2*W-1:W] * rt_mp_ff[W];
         s_m1_ff    <= rt_s_ff[W];
         r_m1_ff    <= rt_root_ff[W];
         mp_m1_ff   <= rt_mp_ff[W];
         mq_m1_ff   <= rt_mq_ff[W];
         sp_m1_ff   <= rt_sp_ff[W];
         sq_m1_ff   <= rt_sq_ff[W];
         sc_m1_ff   <= rt_sc_ff[W];
         near_m1_ff <= rt_near_ff[W];

         d_m2_ff    <= (3*W)'(dlo_ff) + {dhi_ff, {W{1'b0}}};
         nq_m2_ff   <= (3*W)'(nqlo_ff) + {nqhi_ff, {W{1'b0}}};
         np_m2_ff   <= (3*W)'(nplo_ff) + {nphi_ff, {W{1'b0}}};
         s_m2_ff    <= s_m1_ff;
         r_m2_ff    <= r_m1_ff;
         mp_m2_ff   <= mp_m1_ff;
         mq_m2_ff   <= mq_m1_ff;
         sp_m2_ff   <= sp_m1_ff;
         sq_m2_ff   <= sq_m1_ff;
         sc_m2_ff   <= sc_m1_ff;
         near_m2_ff <= near_m1_ff;
      end
   end

   // Six dividers, one quotient bit per stage
   logic [W-1:0] q_rdx, q_rdy, q_bdx, q_bdy, q_tdx, q_tdy;
   logic o_rdx, o_rdy, o_bdx, o_bdy, o_tdx, o_tdy;

   rmj_div #(.NUM_W(W+F), .DEN_W(W), .Q_W(W)) u_div_rdx (
      .clock(clock), .advance(advance), .num_i({mp_m2_ff, {F{1'b0}}}),
      .den_i(r_m2_ff), .quot_o(q_rdx), .ovf_o(o_rdx));
   rmj_div #(.NUM_W(W+F), .DEN_W(W), .Q_W(W)) u_div_rdy (
      .clock(clock), .advance(advance), .num_i({mq_m2_ff, {F{1'b0}}}),
      .den_i(r_m2_ff), .quot_o(q_rdy), .ovf_o(o_rdy));
   rmj_div #(.NUM_W(W+2*F), .DEN_W(2*W), .Q_W(W)) u_div_bdx (
      .clock(clock), .advance(advance), .num_i({mq_m2_ff, {(2*F){1'b0}}}),
      .den_i(s_m2_ff), .quot_o(q_bdx), .ovf_o(o_bdx));
   rmj_div #(.NUM_W(W+2*F), .DEN_W(2*W), .Q_W(W)) u_div_bdy (
      .clock(clock), .advance(advance), .num_i({mp_m2_ff, {(2*F){1'b0}}}),
      .den_i(s_m2_ff), .quot_o(q_bdy), .ovf_o(o_bdy));
   rmj_div #(.NUM_W(3*W+F), .DEN_W(3*W), .Q_W(W)) u_div_tdx (
      .clock(clock), .advance(advance), .num_i({nq_m2_ff, {F{1'b0}}}),
      .den_i(d_m2_ff), .quot_o(q_tdx), .ovf_o(o_tdx));
   rmj_div #(.NUM_W(3*W+F), .DEN_W(3*W), .Q_W(W)) u_div_tdy (
      .clock(clock), .advance(advance), .num_i({np_m2_ff, {F{1'b0}}}),
      .den_i(d_m2_ff), .quot_o(q_tdy), .ovf_o(o_tdy));

   // Carry signs and the flag alongside the dividers
   logic dv_sp_ff [0:W];
   logic dv_sq_ff [0:W];
   logic dv_sc_ff [0:W];
   logic dv_near_ff [0:W];

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_sp_ff[0]   <= sp_m2_ff;
         dv_sq_ff[0]   <= sq_m2_ff;
         dv_sc_ff[0]   <= sc_m2_ff;
         dv_near_ff[0] <= near_m2_ff;
         for (int j = 1; j <= W; j++) begin
            dv_sp_ff[j]   <= dv_sp_ff[j-1];
            dv_sq_ff[j]   <= dv_sq_ff[j-1];
            dv_sc_ff[j]   <= dv_sc_ff[j-1];
            dv_near_ff[j] <= dv_near_ff[j-1];
         end
      end
   end

   // Output register: apply signs, saturate, zero on near range
   logic [6*W-1:0] ent_in;
   logic [6*W-1:0] ent_ff;
   logic near_ff;
   logic sp_o, sq_o, sc_o;

   assign sp_o = dv_sp_ff[W];
   assign sq_o = dv_sq_ff[W];
   assign sc_o = dv_sc_ff[W];

   always_comb begin
      ent_in = {sat_f(q_tdy, o_tdy, ~(sp_o ^ sc_o)),
                sat_f(q_tdx, o_tdx, sq_o ^ sc_o),
                sat_f(q_bdy, o_bdy, sp_o),
                sat_f(q_bdx, o_bdx, ~sq_o),
                sat_f(q_rdy, o_rdy, sq_o),
                sat_f(q_rdx, o_rdx, sp_o)};
      if (dv_near_ff[W]) ent_in = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ent_ff  <= ent_in;
         near_ff <= dv_near_ff[W];
      end
   end

   assign rsp_tdata = OUT_TW'(ent_ff);
   assign rsp_tuser = near_ff;

endmodule

// ----- sv/rmj_div.sv -----
module rmj_div #(
   parameter int unsigned NUM_W = 48,
   parameter int unsigned DEN_W = 32,
   parameter int unsigned Q_W = 32
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0] den_i,
   output logic [Q_W-1:0]   quot_o,
   output logic             ovf_o
);

   localparam int unsigned HI_W = NUM_W - Q_W;
   localparam int unsigned CW = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [0:Q_W];
   logic [Q_W-1:0]   low_ff [0:Q_W];
   logic [DEN_W-1:0] den_ff [0:Q_W];
   logic [Q_W-1:0]   quot_ff [0:Q_W];
   logic             ovf_ff [0:Q_W];

   logic [CW-1:0] hi_c;
   logic [CW-1:0] den_c;

   // Quotient would need more than Q_W bits
   assign hi_c  = CW'(num_i[NUM_W-1:Q_W]);
   assign den_c = CW'(den_i);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= DEN_W'(num_i[NUM_W-1:Q_W]);
         low_ff[0]  <= num_i[Q_W-1:0];
         den_ff[0]  <= den_i;
         quot_ff[0] <= '0;
         ovf_ff[0]  <= (hi_c >= den_c);
      end
   end

   genvar i;
   generate
      for (i = 1; i <= Q_W; i++) begin : g_step
         logic [DEN_W:0] trial_in;
         logic           ge_in;
         logic [DEN_W:0] diff_in;

         assign trial_in = {rem_ff[i-1], low_ff[i-1][Q_W-i]};
         assign ge_in    = (trial_in >= {1'b0, den_ff[i-1]});
         assign diff_in  = trial_in - {1'b0, den_ff[i-1]};

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[i]  <= ge_in ? diff_in[DEN_W-1:0] : trial_in[DEN_W-1:0];
               low_ff[i]  <= low_ff[i-1];
               den_ff[i]  <= den_ff[i-1];
               quot_ff[i] <= quot_ff[i-1] | (Q_W'(ge_in) << (Q_W - i));
               ovf_ff[i]  <= ovf_ff[i-1];
            end
         end
      end
   endgenerate

   assign quot_o = quot_ff[Q_W];
   assign ovf_o  = ovf_ff[Q_W];

endmodule
